@@ rtl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the piecewise linear interpolator
// Breakpoint record, operation and status codes, controller states and
// table and divider sizes.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DIV_STEPS   = 64;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_DUP   = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_BADX  = 3'd3,
        STAT_EMPTY = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CALC,
        S_MUL0,
        S_MUL1,
        S_SUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    // One breakpoint
    typedef struct packed {
        logic               yd;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } point_t;

    // Control from the sequencer to one cell
    typedef struct packed {
        logic load;
        logic valid;
    } cell_ctrl_t;

    // Compare results of one cell against the key
    typedef struct packed {
        logic ins;
        logic ge;
        logic eq;
    } cell_flags_t;

endpackage

@@ rtl/pli_cell.sv @@
// ----------------------------------------------------------------------------
// pli_cell: one slot of the sorted breakpoint chain
// Holds one breakpoint, compares it with the key and on an insert either
// keeps it, takes its left neighbor's point or takes the new point.
// ----------------------------------------------------------------------------
module pli_cell
    import pli_pkg::*;
(
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] key,
    input  point_t             new_pt,
    input  point_t             left_pt,
    input  logic               left_ins,
    output point_t             pt,
    output cell_flags_t        flags
);

    point_t pt_reg;

    // Compare the held point with the key; an empty slot always takes part
    always_comb begin
        flags.ins = !ctrl.valid || (pt_reg.x > key);
        flags.ge  = ctrl.valid && (pt_reg.x >= key);
        flags.eq  = ctrl.valid && (pt_reg.x == key);
    end

    // Shift right on insert: take the neighbor if it moves too, else the new point
    always_ff @(posedge aclk) begin
        if (ctrl.load && flags.ins) begin
            pt_reg <= left_ins ? left_pt : new_pt;
        end
    end

    assign pt = pt_reg;

endmodule

@@ rtl/pli_divider.sv @@
// ----------------------------------------------------------------------------
// pli_divider: serial signed divider
// Divides a signed 64-bit numerator by a positive 33-bit denominator, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pli_divider
    import pli_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic        [32:0] den,
    output logic               done,
    output logic signed [31:0] quo
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [63:0]          work_reg;
    logic [33:0]          rem_reg;
    logic [32:0]          den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [33:0]          rem_sh;
    logic [34:0]          diff;
    logic                 fits;

    // One restoring step
    always_comb begin
        rem_sh = {rem_reg[32:0], work_reg[63]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        fits   = !diff[34];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            neg_reg  <= num[63];
            work_reg <= num[63] ? 64'(-num) : num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[33:0] : rem_sh;
            work_reg <= {work_reg[62:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(work_reg[31:0]) : $signed(work_reg[31:0]);

endmodule

@@ rtl/piecewise_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: sorted breakpoint table with interpolation
// Input words carry an operation in s_tuser: clear the table, load one
// breakpoint (x, y, y defined) or query y at x. Every input word yields
// exactly one result word with the interpolated value, its defined flag and
// a status code (ok, duplicate x ignored, table full, undefined x, empty).
// Breakpoints live in a chain of TABLE_DEPTH cells kept sorted by x; a load
// shifts the cells above the insert point right by one, all at the same time.
// Clear, load and rejected items go from S_EXEC straight to S_DONE; a
// clamped or exact query passes through S_CALC; an interpolated query runs
// S_CALC, S_MUL0, S_MUL1, S_SUM and the 64-step serial divider first.
// One word is processed at a time; s_tready is high only while idle, and a
// new word can be accepted while the previous result still waits in the
// output register.
// Reset empties the table (the point count clears) and drops any pending
// result. When the receiver stalls, the result holds in m_tdata and the
// finished next item waits in its final state until the register frees.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator
    import pli_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic [71:0] s_tdata,   // [31:0] x_value, [32] x_valid, [64:33] y_value,
                                   // [65] y_valid, [71:66] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] result_value, [32] result_valid,
                                   // [35:33] status, [39:36] zero
);

    state_t state_reg, state_next;

    op_t                op_reg;
    logic signed [31:0] x_reg;
    logic               xv_reg;
    logic signed [31:0] y_reg;
    logic               yv_reg;
    logic [CNT_W-1:0]   count_reg;

    point_t             p_reg, m_reg;
    logic               pick_reg;
    logic signed [32:0] dpx_reg, dxm_reg;
    logic signed [64:0] prod_reg;
    logic signed [63:0] acc_reg;

    logic signed [31:0] res_reg;
    logic               rv_reg;
    status_t            st_reg;

    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    point_t             pts   [TABLE_DEPTH];
    cell_flags_t        flags [TABLE_DEPTH];
    logic               load_en;
    point_t             new_pt;

    logic               any_eq, any_ge;
    point_t             sel_m, sel_p, sel_last;
    logic               first0;

    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;

    logic               div_start, div_done;
    logic signed [31:0] div_quo;
    logic               out_free;

    assign new_pt = '{yd: yv_reg, y: y_reg, x: x_reg};

    // Chain of breakpoint cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        cell_ctrl_t ctrl;
        assign ctrl.load  = load_en;
        assign ctrl.valid = count_reg > CNT_W'(i);
        if (i == 0) begin : g_head
            pli_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .key      (x_reg),
                .new_pt   (new_pt),
                .left_pt  (new_pt),
                .left_ins (1'b0),
                .pt       (pts[i]),
                .flags    (flags[i])
            );
        end else begin : g_body
            pli_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .key      (x_reg),
                .new_pt   (new_pt),
                .left_pt  (pts[i-1]),
                .left_ins (flags[i-1].ins),
                .pt       (pts[i]),
                .flags    (flags[i])
            );
        end
    end

    // Find the bracket: first cell at or above the key, its left neighbor, the last cell
    always_comb begin
        any_eq   = 1'b0;
        any_ge   = 1'b0;
        sel_m    = '0;
        sel_p    = '0;
        sel_last = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            any_eq = any_eq | flags[i].eq;
            any_ge = any_ge | flags[i].ge;
            if (flags[i].ge && (i == 0 || !flags[(i == 0) ? 0 : i-1].ge)) begin
                sel_m = sel_m | pts[i];
            end
            if (i < TABLE_DEPTH - 1) begin
                if (flags[i+1].ge && !flags[i].ge) begin
                    sel_p = sel_p | pts[i];
                end
            end
            if (count_reg == CNT_W'(i + 1)) begin
                sel_last = sel_last | pts[i];
            end
        end
        first0 = flags[0].ge;
    end

    // Shared multiplier
    always_comb begin
        if (state_reg == S_MUL0) begin
            mul_a = p_reg.y;
            mul_b = dxm_reg;
        end else begin
            mul_a = m_reg.y;
            mul_b = dpx_reg;
        end
        mul_p = mul_a * mul_b;
    end

    pli_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_reg),
        .den     (33'(dpx_reg + dxm_reg)),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_EXEC;
            S_EXEC: begin
                if (op_reg == OP_QUERY && xv_reg && count_reg != '0) begin
                    state_next = S_CALC;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CALC: begin
                if (pick_reg || !(p_reg.yd && m_reg.yd)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MUL0;
                end
            end
            S_MUL0:      state_next = S_MUL1;
            S_MUL1:      state_next = S_SUM;
            S_SUM:       state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:  if (div_done) state_next = S_DONE;
            S_DONE:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs and strobes
    always_comb begin
        s_tready  = 1'b0;
        load_en   = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:      s_tready = 1'b1;
            S_EXEC:      load_en = (op_reg == OP_LOAD) && xv_reg && !any_eq
                                   && (count_reg != CNT_W'(TABLE_DEPTH));
            S_DIV_START: div_start = 1'b1;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_EXEC && op_reg == OP_CLEAR) begin
                count_reg <= '0;
            end else if (load_en) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_reg <= op_t'(s_tuser);
                    x_reg  <= s_tdata[31:0];
                    xv_reg <= s_tdata[32];
                    y_reg  <= s_tdata[64:33];
                    yv_reg <= s_tdata[65];
                end
            end
            S_EXEC: begin
                res_reg  <= '0;
                rv_reg   <= 1'b0;
                st_reg   <= STAT_OK;
                p_reg    <= sel_p;
                m_reg    <= any_ge ? sel_m : sel_last;
                pick_reg <= !any_ge || first0 || (sel_m.x == x_reg);
                case (op_reg)
                    OP_LOAD: begin
                        if (!xv_reg) begin
                            st_reg <= STAT_BADX;
                        end else if (any_eq) begin
                            st_reg <= STAT_DUP;
                        end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            st_reg <= STAT_FULL;
                        end
                    end
                    OP_QUERY: begin
                        if (!xv_reg) begin
                            st_reg <= STAT_BADX;
                        end else if (count_reg == '0) begin
                            st_reg <= STAT_EMPTY;
                        end
                    end
                    default: begin
                        st_reg <= STAT_OK;
                    end
                endcase
            end
            S_CALC: begin
                if (pick_reg) begin
                    res_reg <= m_reg.yd ? m_reg.y : '0;
                    rv_reg  <= m_reg.yd;
                end
                dpx_reg <= 33'(x_reg) - 33'(p_reg.x);
                dxm_reg <= 33'(m_reg.x) - 33'(x_reg);
            end
            S_MUL0: prod_reg <= mul_p;
            S_MUL1: begin
                acc_reg  <= prod_reg[63:0];
                prod_reg <= mul_p;
            end
            S_SUM: acc_reg <= acc_reg + prod_reg[63:0];
            S_DIV_WAIT: begin
                if (div_done) begin
                    res_reg <= div_quo;
                    rv_reg  <= 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {4'b0000, st_reg, rv_reg, res_reg};
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
